// ===== rtl/prefix_match_route_lookup_core_assert.svh =====
// Assertion helpers used by the checker file.
`ifndef PREFIX_MATCH_ROUTE_LOOKUP_CORE_ASSERT_SVH
`define PREFIX_MATCH_ROUTE_LOOKUP_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PMRL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PMRL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pmrl_pkg.sv =====
package pmrl_pkg;

	localparam int ADDR_W  = 32;
	localparam int LEN_W   = 6;
	localparam int HOP_W   = 8;
	localparam int OP_W    = 2;
	localparam int KIND_W  = 2;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

	// what a chain slot carries
	localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

	typedef struct packed {
		logic [ADDR_W-1:0] address;
		logic [LEN_W-1:0]  len;
		logic [HOP_W-1:0]  hop;
		logic [LEN_W-1:0]  score;
		logic              found;
	} item_t;

	// count of leading agreeing bits, 0..32, by halving search
	function automatic logic [LEN_W-1:0] lead_agree(input logic [ADDR_W-1:0] a,
			input logic [ADDR_W-1:0] b);
		logic [ADDR_W-1:0] v;
		logic [LEN_W-1:0]  n;
		v = a ^ b;
		n = '0;
		if (v[31:16] == 16'd0) begin
			n = n + 6'd16;
			v = {v[15:0], 16'd0};
		end
		if (v[31:24] == 8'd0) begin
			n = n + 6'd8;
			v = {v[23:0], 8'd0};
		end
		if (v[31:28] == 4'd0) begin
			n = n + 6'd4;
			v = {v[27:0], 4'd0};
		end
		if (v[31:30] == 2'd0) begin
			n = n + 6'd2;
			v = {v[29:0], 2'd0};
		end
		if (!v[31]) begin
			n = n + 6'd1;
			v = {v[30:0], 1'b0};
		end
		if (!v[31]) begin
			n = n + 6'd1;
		end
		return n;
	endfunction

endpackage

// ===== rtl/prefix_match_route_lookup_core.sv =====
// channel  dir  tdata                                         tuser
// s_axis   in   address[31:0] prefix_len[37:32] next_hop[45:38]  op[1:0]
// m_axis   out  hop[7:0] best_score[13:8]                     found[0]
//
// Every item walks a chain of TABLE_DEPTH route cells, one cell per cycle unless stalled.
// One item enters per cycle unless stalled; a lookup result passes the input register,
// the cell chain and the output register before it shows.
// Clear and add give no result; an add lands in its cell as it passes.
// A held result stalls the whole chain and the input together.
// Reset empties the table; stored routes keep their contents.
module prefix_match_route_lookup_core #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // address, prefix_len, next_hop, zero pad
	input  logic [1:0]  s_axis_tuser,   // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // hop, best_score, zero pad
	output logic        m_axis_tuser    // found
);
	import pmrl_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(TABLE_DEPTH);

	logic              adv;
	logic              accept;
	logic [OP_W-1:0]   op;
	logic [CNT_W-1:0]  count_q;
	logic [KIND_W-1:0] kind_c;
	item_t             item_c;

	logic [KIND_W-1:0] kind_s0;
	item_t             item_s0;
	logic [CNT_W-1:0]  cnt_s0;

	logic [KIND_W-1:0] kind_w [0:TABLE_DEPTH];
	item_t             item_w [0:TABLE_DEPTH];
	logic [CNT_W-1:0]  cnt_w  [0:TABLE_DEPTH];

	logic              out_valid_q;
	item_t             res_q;

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;
	assign op            = s_axis_tuser;

	always_comb begin
		kind_c = KIND_NONE;
		if (accept) begin
			unique case (op)
				OP_ADD:    kind_c = (count_q != FULL) ? KIND_ADD : KIND_NONE;
				OP_LOOKUP: kind_c = KIND_LOOKUP;
				default:   kind_c = KIND_NONE;
			endcase
		end
		item_c.address = s_axis_tdata[31:0];
		item_c.len     = s_axis_tdata[37:32];
		item_c.hop     = (op == OP_LOOKUP) ? '0 : s_axis_tdata[45:38];
		item_c.score   = '0;
		item_c.found   = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			unique case (op)
				OP_CLEAR: count_q <= '0;
				OP_ADD:   if (count_q != FULL) count_q <= count_q + 1'b1;
				default:  count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s0 <= KIND_NONE;
		end else if (adv) begin
			kind_s0 <= kind_c;
		end
	end

	// count snapshot: write slot for an add, live entries for a lookup
	always_ff @(posedge clk) begin
		if (adv) begin
			item_s0 <= item_c;
			cnt_s0  <= count_q;
		end
	end

	assign kind_w[0] = kind_s0;
	assign item_w[0] = item_s0;
	assign cnt_w[0]  = cnt_s0;

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		pmrl_cell #(
			.CNT_W (CNT_W),
			.INDEX (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_kind  (kind_w[k]),
			.in_item  (item_w[k]),
			.in_cnt   (cnt_w[k]),
			.out_kind (kind_w[k+1]),
			.out_item (item_w[k+1]),
			.out_cnt  (cnt_w[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= (kind_w[TABLE_DEPTH] == KIND_LOOKUP);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= item_w[TABLE_DEPTH];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, res_q.score, res_q.hop};
	assign m_axis_tuser  = res_q.found;

endmodule

// ===== rtl/pmrl_cell.sv =====
module pmrl_cell #(
	parameter int CNT_W = 7,
	parameter int INDEX = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic [1:0]               in_kind,
	input  pmrl_pkg::item_t          in_item,
	input  logic [CNT_W-1:0]         in_cnt,
	output logic [1:0]               out_kind,
	output pmrl_pkg::item_t          out_item,
	output logic [CNT_W-1:0]         out_cnt
);
	import pmrl_pkg::*;

	localparam logic [CNT_W-1:0] SLOT = CNT_W'(INDEX);

	logic [ADDR_W-1:0] prefix_q;
	logic [LEN_W-1:0]  len_q;
	logic [HOP_W-1:0]  hop_q;

	logic [KIND_W-1:0] kind_s1;
	item_t             item_s1;
	logic [CNT_W-1:0]  cnt_s1;

	logic [LEN_W-1:0]  raw_score;
	logic [LEN_W-1:0]  score;
	logic              live;
	item_t             nxt;

	assign live      = (in_cnt > SLOT);
	assign raw_score = lead_agree(in_item.address, prefix_q);
	assign score     = (raw_score > len_q) ? len_q : raw_score;

	// later entries win ties, so take on equal score
	always_comb begin
		nxt = in_item;
		if (in_kind == KIND_LOOKUP && live && (!in_item.found || score >= in_item.score)) begin
			nxt.score = score;
			nxt.hop   = hop_q;
			nxt.found = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_kind == KIND_ADD && in_cnt == SLOT) begin
			prefix_q <= in_item.address;
			len_q    <= in_item.len;
			hop_q    <= in_item.hop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s1 <= KIND_NONE;
		end else if (adv) begin
			kind_s1 <= in_kind;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= nxt;
			cnt_s1  <= in_cnt;
		end
	end

	assign out_kind = kind_s1;
	assign out_item = item_s1;
	assign out_cnt  = cnt_s1;

endmodule

// ===== rtl/pmrl_chk.sv =====
`include "prefix_match_route_lookup_core_assert.svh"

module pmrl_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [47:0] s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// hold a stalled result
	`PMRL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"stalled result changed")

	// input takes a transfer exactly when the result slot frees up
	`PMRL_ASSERT_NOW(a_ready_tracks_out, 1'b1,
		s_axis_tready == (!m_axis_tvalid || m_axis_tready),
		"input ready does not follow output slot")

	// an empty-table answer carries zero hop and score
	`PMRL_ASSERT_NOW(a_miss_zero, m_axis_tvalid && !m_axis_tuser,
		m_axis_tdata == 16'd0, "miss result with nonzero fields")

	// score never exceeds the address width, pad stays clear
	`PMRL_ASSERT_NOW(a_score_range, m_axis_tvalid,
		m_axis_tdata[13:8] <= 6'd32 && m_axis_tdata[15:14] == 2'b00,
		"score out of range")

endmodule

bind prefix_match_route_lookup_core pmrl_chk u_pmrl_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ===== tb/prefix_match_route_checker.sv =====
module prefix_match_route_checker #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // address, prefix_len, next_hop, zero pad
	input  logic [1:0]  s_axis_tuser,   // op
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,   // hop, best_score, zero pad
	input  logic        m_axis_tuser,   // found
	output int unsigned mismatches,
	output int unsigned awaiting,
	output int unsigned checked
);
	import pmrl_pkg::*;

	typedef struct packed {
		logic [HOP_W-1:0] hop;
		logic [LEN_W-1:0] score;
		logic             found;
	} route_hit_t;

	logic [ADDR_W-1:0] route_prefix_mem [TABLE_DEPTH];
	logic [LEN_W-1:0]  route_len_mem    [TABLE_DEPTH];
	logic [HOP_W-1:0]  route_hop_mem    [TABLE_DEPTH];
	int unsigned       routes_held;
	route_hit_t        hit_expect_q [$];

	function automatic int unsigned agree_bits(input logic [ADDR_W-1:0] a,
			input logic [ADDR_W-1:0] b);
		logic [ADDR_W-1:0] diff;
		int unsigned       n;
		diff = a ^ b;
		n = 0;
		for (int k = ADDR_W - 1; k >= 0; k--) begin
			if (diff[k])
				break;
			n++;
		end
		return n;
	endfunction

	// later routes win ties, so compare with >=
	function automatic route_hit_t best_route(input logic [ADDR_W-1:0] key);
		route_hit_t  hit;
		int unsigned s;
		hit = '0;
		for (int i = 0; i < routes_held; i++) begin
			s = agree_bits(key, route_prefix_mem[i]);
			if (s > route_len_mem[i])
				s = route_len_mem[i];
			if (!hit.found || s >= hit.score) begin
				hit.hop   = route_hop_mem[i];
				hit.score = s[LEN_W-1:0];
				hit.found = 1'b1;
			end
		end
		return hit;
	endfunction

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch in result %0d, %s: expected %0d, got %0d",
					checked, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		route_hit_t want;
		route_hit_t got;
		if (!arst_n) begin
			routes_held = 0;
			hit_expect_q.delete();
			mismatches = 0;
			awaiting = 0;
			checked = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.hop   = m_axis_tdata[7:0];
				got.score = m_axis_tdata[13:8];
				got.found = m_axis_tuser;
				if (hit_expect_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: hop %0d, best_score %0d, found %0d",
							got.hop, got.score, got.found);
				end else begin
					want = hit_expect_q.pop_front();
					compare_field("hop", want.hop, got.hop);
					compare_field("best_score", want.score, got.score);
					compare_field("found", want.found, got.found);
				end
				checked++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				case (s_axis_tuser)
					OP_CLEAR: routes_held = 0;
					OP_ADD: begin
						// drop the route once the table is full
						if (routes_held < TABLE_DEPTH) begin
							route_prefix_mem[routes_held] = s_axis_tdata[31:0];
							route_len_mem[routes_held]    = s_axis_tdata[37:32];
							route_hop_mem[routes_held]    = s_axis_tdata[45:38];
							routes_held++;
						end
					end
					OP_LOOKUP: hit_expect_q = {hit_expect_q, best_route(s_axis_tdata[31:0])};
					default: ;
				endcase
			end
			awaiting = hit_expect_q.size();
		end
	end

endmodule

// ===== tb/tb_prefix_match_route_lookup_core.sv =====
module tb_prefix_match_route_lookup_core;
	import pmrl_pkg::*;

	localparam int          TABLE_DEPTH = 64;
	localparam int unsigned STIM_ITEMS  = 1250;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_DUTY, RX_CHOKE} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;   // address, prefix_len, next_hop, zero pad
	logic [1:0]  s_axis_tuser = '0;   // op
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // hop, best_score, zero pad
	logic        m_axis_tuser;        // found

	int unsigned mismatches;
	int unsigned awaiting;
	int unsigned checked;

	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	int unsigned stim_count = 0;
	int unsigned clears_sent = 0;
	int unsigned adds_sent = 0;
	int unsigned adds_dropped = 0;
	int unsigned lookups_sent = 0;
	int unsigned routes_loaded = 0;
	logic [ADDR_W-1:0] prefix_pool [$];

	rx_mode_t    rx_mode = RX_OPEN;
	int unsigned rx_left = 0;
	int unsigned rx_tick = 0;

	prefix_match_route_lookup_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	prefix_match_route_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.mismatches   (mismatches),
		.awaiting     (awaiting),
		.checked      (checked)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, awaiting);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// result side backpressure: switch between open, random, duty-cycle and choked
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 300);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_OPEN: m_axis_tready <= 1'b1;
			RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
			RX_DUTY: m_axis_tready <= (rx_tick % 5) < 3;
			default: m_axis_tready <= (rx_tick % 16) == 0;
		endcase
	end

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_route_op(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
			input logic [LEN_W-1:0] len, input logic [HOP_W-1:0] hop);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(5, 20)) @(negedge clk);
			else
				repeat ($urandom_range(1, 3)) @(negedge clk);
			burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(40, 200)
				: $urandom_range(1, 12);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, hop, len, addr};
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
		case (op)
			OP_CLEAR: begin
				clears_sent++;
				routes_loaded = 0;
			end
			OP_ADD: begin
				adds_sent++;
				if (routes_loaded < TABLE_DEPTH)
					routes_loaded++;
				else
					adds_dropped++;
				prefix_pool = {prefix_pool, addr};
				if (prefix_pool.size() > TABLE_DEPTH)
					void'(prefix_pool.pop_front());
			end
			OP_LOOKUP: lookups_sent++;
			default: ;
		endcase
		if (op != OP_UNUSED)
			stim_count++;
	endtask

	// address close to a known prefix: keep a random number of leading bits
	function automatic logic [ADDR_W-1:0] pick_near_prefix();
		logic [ADDR_W-1:0] base;
		if (prefix_pool.size() == 0 || $urandom_range(0, 3) == 0)
			return $urandom();
		base = prefix_pool[$urandom_range(0, prefix_pool.size() - 1)];
		return base ^ ($urandom() >> $urandom_range(0, 32));
	endfunction

	function automatic logic [LEN_W-1:0] pick_prefix_len();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 8)
			return LEN_W'($urandom_range(0, 32));
		if (r == 8)
			return 6'd32;
		return LEN_W'($urandom_range(33, 63));
	endfunction

	initial begin
		int unsigned       stim_target;
		int unsigned       n_adds;
		logic [ADDR_W-1:0] addr;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// empty table, unused op, catch-all route, host route and ties
		send_route_op(OP_LOOKUP, 32'h0000_0000, 6'd0, 8'h00);
		send_route_op(OP_UNUSED, 32'hFFFF_FFFF, 6'd63, 8'hFF);
		send_route_op(OP_ADD, 32'h0000_0000, 6'd0, 8'h11);
		send_route_op(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'h00);
		send_route_op(OP_ADD, 32'hFFFF_FFFF, 6'd32, 8'hFF);
		send_route_op(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'h00);
		send_route_op(OP_LOOKUP, 32'h0000_0000, 6'd0, 8'h00);
		send_route_op(OP_ADD, 32'h0000_0000, 6'd63, 8'h00);
		send_route_op(OP_LOOKUP, 32'h0000_0000, 6'd0, 8'h00);
		send_route_op(OP_ADD, 32'hFFFF_0000, 6'd16, 8'hA5);
		send_route_op(OP_ADD, 32'hFFFF_0000, 6'd16, 8'h5A);
		send_route_op(OP_LOOKUP, 32'hFFFF_1234, 6'd0, 8'h00);
		send_route_op(OP_LOOKUP, 32'h8000_0001, 6'd0, 8'h00);
		send_route_op(OP_CLEAR, 32'hFFFF_FFFF, 6'd63, 8'hFF);
		send_route_op(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'h00);
		send_route_op(OP_ADD, 32'h8000_0000, 6'd1, 8'h01);
		send_route_op(OP_LOOKUP, 32'h7FFF_FFFF, 6'd0, 8'h00);
		send_route_op(OP_LOOKUP, 32'h8000_0000, 6'd0, 8'h00);
		send_route_op(OP_ADD, 32'hC0A8_0101, 6'd32, 8'h00);
		send_route_op(OP_LOOKUP, 32'hC0A8_0101, 6'd0, 8'h00);
		send_route_op(OP_LOOKUP, 32'hC0A8_0100, 6'd0, 8'h00);

		stim_target = stim_count + STIM_ITEMS;
		while (stim_count < stim_target) begin
			if ($urandom_range(0, 99) < 85) begin
				n_adds = ($urandom_range(0, 11) == 0) ? $urandom_range(56, 72)
					: $urandom_range(0, 6);
				if (n_adds > 40 || $urandom_range(0, 2) == 0)
					send_route_op(OP_CLEAR, $urandom(), 6'($urandom()), 8'($urandom()));
				repeat (n_adds) begin
					// exact duplicates make ties between routes
					if (prefix_pool.size() != 0 && $urandom_range(0, 4) == 0)
						addr = prefix_pool[$urandom_range(0, prefix_pool.size() - 1)];
					else
						addr = pick_near_prefix();
					send_route_op(OP_ADD, addr, pick_prefix_len(), 8'($urandom()));
				end
				repeat ($urandom_range(1, 6))
					send_route_op(OP_LOOKUP, pick_near_prefix(), 6'($urandom()),
						8'($urandom()));
			end else begin
				repeat ($urandom_range(1, 4))
					send_route_op(2'($urandom_range(0, 3)), $urandom(), 6'($urandom()),
						8'($urandom()));
			end
		end
		s_axis_tvalid <= 1'b0;

		while (awaiting != 0)
			@(negedge clk);
		repeat (TABLE_DEPTH + 8) @(negedge clk);

		$display("stimulus: %0d clears, %0d adds (%0d into a full table), %0d lookups",
			clears_sent, adds_sent, adds_dropped, lookups_sent);
		$display("lookup results compared: %0d, mismatches: %0d", checked, mismatches);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
